// ===== design/lbpfm_pkg.sv =====
// ---------------------------------------------------------------------------
// lbpfm_pkg: shared types and constants for the buffer pool frame manager
// Frame count, field widths, request and command codes.
// ---------------------------------------------------------------------------
`default_nettype none
package lbpfm_pkg;
  localparam int FRAMES      = 16;
  localparam int STAMP_WIDTH = 32;
  localparam int FIDX_W      = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W       = $clog2(FRAMES + 1);
  localparam int PAGE_W      = 32;
  localparam int PIN_W       = 16;
  localparam int CAP_W       = 5;

  typedef enum logic [1:0] {
    FUNC_FETCH = 2'd0, FUNC_UNPIN = 2'd1, FUNC_FLUSH = 2'd2, FUNC_FLUSH_ALL = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0, CMD_WRITEBACK = 2'd1, CMD_READ = 2'd2, CMD_SYNC = 2'd3
  } cmd_t;

  // one metadata entry; page, pin, dirty, stamp share a memory word
  typedef struct packed {
    logic [PAGE_W-1:0]      page;
    logic [PIN_W-1:0]       pin;
    logic                   dirty;
    logic [STAMP_WIDTH-1:0] stamp;
  } meta_t;

  localparam int META_W = $bits(meta_t);

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] page_id;
    logic        set_dirty;
  } req_t;

  typedef struct packed {
    logic        status;
    logic        hit;
    logic [3:0]  frame;
    logic [1:0]  cmd;
    logic [31:0] cmd_page;
    logic [3:0]  cmd_frame;
    logic        last;
  } rsp_t;
endpackage
`default_nettype wire

// ===== design/lbpfm_if.sv =====
// ---------------------------------------------------------------------------
// lbpfm_if: valid/ready channel interfaces
// Request and result channels with source and sink modports.
// ---------------------------------------------------------------------------
`default_nettype none
interface lbpfm_req_if import lbpfm_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] page_id;
  logic        set_dirty;
  modport source (output valid, func, page_id, set_dirty, input ready);
  modport sink   (input valid, func, page_id, set_dirty, output ready);
endinterface

interface lbpfm_rsp_if import lbpfm_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        status;
  logic        hit;
  logic [3:0]  frame;
  logic [1:0]  cmd;
  logic [31:0] cmd_page;
  logic [3:0]  cmd_frame;
  logic        last;
  modport source (output valid, status, hit, frame, cmd, cmd_page, cmd_frame, last,
                  input ready);
  modport sink   (input valid, status, hit, frame, cmd, cmd_page, cmd_frame, last,
                  output ready);
endinterface
`default_nettype wire

// ===== design/lbpfm_ram.sv =====
// ---------------------------------------------------------------------------
// lbpfm_ram: generic single-port-write, single-read RAM
// Registered read.
// ---------------------------------------------------------------------------
`default_nettype none
module lbpfm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== design/lbpfm_out.sv =====
// ---------------------------------------------------------------------------
// lbpfm_out: result register
// Holds one result; accepts a new one whenever empty or being drained.
// ---------------------------------------------------------------------------
`default_nettype none
module lbpfm_out import lbpfm_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire rsp_t      push_data,
  output logic           can_push,
  lbpfm_rsp_if.source    rsp
);
  logic full;
  rsp_t data;

  assign can_push = !full || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (push) begin
      full <= 1'b1;
    end else if (rsp.ready) begin
      full <= 1'b0;
    end
    if (push) begin
      data <= push_data;
    end
  end

  assign rsp.valid     = full;
  assign rsp.status    = data.status;
  assign rsp.hit       = data.hit;
  assign rsp.frame     = data.frame;
  assign rsp.cmd       = data.cmd;
  assign rsp.cmd_page  = data.cmd_page;
  assign rsp.cmd_frame = data.cmd_frame;
  assign rsp.last      = data.last;

  // a result is never overwritten while still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || rsp.ready)) else $error("result overwritten");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    full && !rsp.ready |=> full) else $error("result dropped");
  a_valid_after_push: assert property (@(posedge clk) disable iff (rst)
    push |=> full) else $error("push lost");
endmodule
`default_nettype wire

// ===== design/lbpfm_ctrl.sv =====
// ---------------------------------------------------------------------------
// lbpfm_ctrl: request sequencer
// Scans the metadata memory one frame a cycle, then updates entries.
// ---------------------------------------------------------------------------
`default_nettype none
module lbpfm_ctrl import lbpfm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [CAP_W-1:0]  capacity,
  lbpfm_req_if.sink              req,
  output logic                   push,
  output rsp_t                   push_data,
  input  wire logic              can_push
);
  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_VREAD, S_EMIT, S_FLUSH
  } state_t;

  state_t              state;
  req_t                cur;
  logic [FRAMES-1:0]   valid_bits;
  logic [STAMP_WIDTH-1:0] use_clock;
  logic [CNT_W-1:0]    scan;        // read address sequence
  logic [FIDX_W-1:0]   rd_idx;      // index of data now on rdata
  logic                rd_ok;
  // scan results
  logic                found;
  logic [FIDX_W-1:0]   found_idx;
  meta_t               found_meta;
  logic                free_ok;
  logic [FIDX_W-1:0]   free_idx;
  logic [CNT_W-1:0]    used;
  logic                vic_ok;
  logic [FIDX_W-1:0]   vic_idx;
  meta_t               vic_meta;
  logic [FIDX_W-1:0]   slot;
  logic                go_emit;     // miss goes on to install a page
  logic                bump;        // use clock advances this cycle

  // memory port
  logic                we;
  logic [FIDX_W-1:0]   waddr;
  meta_t               wdata;
  logic [FIDX_W-1:0]   raddr;
  meta_t               rdata;
  logic [META_W-1:0]   rdata_raw;

  assign rdata = meta_t'(rdata_raw);
  // hold the address of a flushed frame while its writeback waits
  assign raddr = (state == S_FLUSH && rd_ok) ? rd_idx : scan[FIDX_W-1:0];

  lbpfm_ram #(.WIDTH(META_W), .DEPTH(FRAMES)) u_meta (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata_raw)
  );

  assign req.ready = (state == S_IDLE);

  logic [CNT_W-1:0] cap_eff;
  assign cap_eff = (capacity > CAP_W'(FRAMES)) ? CNT_W'(FRAMES) : CNT_W'(capacity);

  logic [STAMP_WIDTH-1:0] tick;
  assign tick = use_clock + 1'b1;

  logic rd_valid;
  assign rd_valid = valid_bits[rd_idx];

  // result and memory write for the current cycle
  always_comb begin
    push      = 1'b0;
    push_data = '0;
    we        = 1'b0;
    waddr     = '0;
    wdata     = '0;
    go_emit   = 1'b0;
    bump      = 1'b0;
    case (state)
      S_DECIDE: begin
        if (can_push) begin
          push           = 1'b1;
          push_data.last = 1'b1;
          case (func_t'(cur.func))
            FUNC_FETCH: begin
              if (found) begin
                push_data.hit   = 1'b1;
                push_data.frame = 4'(found_idx);
                we    = 1'b1;
                waddr = found_idx;
                wdata = '{page: found_meta.page,
                          pin: (found_meta.pin == '1) ? found_meta.pin
                                                      : found_meta.pin + 1'b1,
                          dirty: found_meta.dirty, stamp: tick};
                bump  = 1'b1;
              end else if (cap_eff == '0) begin
                push_data.status = 1'b1;
              end else if (used >= cap_eff) begin
                if (!vic_ok) begin
                  push_data.status = 1'b1;
                end else begin
                  go_emit = 1'b1;
                  if (vic_meta.dirty) begin
                    push_data.last      = 1'b0;
                    push_data.frame     = 4'(vic_idx);
                    push_data.cmd       = CMD_WRITEBACK;
                    push_data.cmd_page  = vic_meta.page;
                    push_data.cmd_frame = 4'(vic_idx);
                  end else begin
                    push = 1'b0;
                  end
                end
              end else if (!free_ok) begin
                push_data.status = 1'b1;
              end else begin
                push    = 1'b0;
                go_emit = 1'b1;
              end
            end
            FUNC_UNPIN: begin
              if (found) begin
                push_data.hit   = 1'b1;
                push_data.frame = 4'(found_idx);
                we    = 1'b1;
                waddr = found_idx;
                wdata = '{page: found_meta.page,
                          pin: (found_meta.pin == '0) ? found_meta.pin
                                                      : found_meta.pin - 1'b1,
                          dirty: found_meta.dirty | cur.set_dirty, stamp: tick};
                bump  = 1'b1;
              end
            end
            default: begin
              if (found) begin
                push_data.hit   = 1'b1;
                push_data.frame = 4'(found_idx);
                if (found_meta.dirty) begin
                  push_data.cmd       = CMD_WRITEBACK;
                  push_data.cmd_page  = cur.page_id;
                  push_data.cmd_frame = 4'(found_idx);
                  we    = 1'b1;
                  waddr = found_idx;
                  wdata = '{page: found_meta.page, pin: found_meta.pin,
                            dirty: 1'b0, stamp: found_meta.stamp};
                end
              end
            end
          endcase
        end
      end
      // install the new page and emit the read command
      S_EMIT: begin
        if (can_push) begin
          push      = 1'b1;
          push_data = '{status: 1'b0, hit: 1'b0, frame: 4'(slot), cmd: CMD_READ,
                        cmd_page: cur.page_id, cmd_frame: 4'(slot), last: 1'b1};
          we    = 1'b1;
          waddr = slot;
          wdata = '{page: cur.page_id, pin: PIN_W'(1), dirty: 1'b0, stamp: tick};
          bump  = 1'b1;
        end
      end
      // flush all: writeback of a valid dirty frame, sync at the end
      S_FLUSH: begin
        if (!rd_ok) begin
          if (scan == CNT_W'(FRAMES) && can_push) begin
            push      = 1'b1;
            push_data = '{status: 1'b0, hit: 1'b0, frame: 4'd0, cmd: CMD_SYNC,
                          cmd_page: '0, cmd_frame: 4'd0, last: 1'b1};
          end
        end else if (rd_valid && rdata.dirty && can_push) begin
          push      = 1'b1;
          push_data = '{status: 1'b0, hit: 1'b0, frame: 4'd0, cmd: CMD_WRITEBACK,
                        cmd_page: rdata.page, cmd_frame: 4'(rd_idx), last: 1'b0};
          we    = 1'b1;
          waddr = rd_idx;
          wdata = '{page: rdata.page, pin: rdata.pin, dirty: 1'b0, stamp: rdata.stamp};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      valid_bits <= '0;
      use_clock  <= '0;
      rd_ok      <= 1'b0;
    end else begin
      if (bump) begin
        use_clock <= tick;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            cur      <= '{func: req.func, page_id: req.page_id, set_dirty: req.set_dirty};
            scan     <= '0;
            rd_ok    <= 1'b0;
            found    <= 1'b0;
            free_ok  <= 1'b0;
            vic_ok   <= 1'b0;
            used     <= '0;
            state    <= S_SCAN;
          end
        end
        // one read issued per cycle; data examined the cycle after
        S_SCAN: begin
          if (rd_ok) begin
            if (rd_valid) begin
              used <= used + 1'b1;
              if (!found && rdata.page == cur.page_id) begin
                found      <= 1'b1;
                found_idx  <= rd_idx;
                found_meta <= rdata;
              end
              if (rdata.pin == '0 && (!vic_ok || rdata.stamp < vic_meta.stamp)) begin
                vic_ok   <= 1'b1;
                vic_idx  <= rd_idx;
                vic_meta <= rdata;
              end
            end else if (!free_ok) begin
              free_ok  <= 1'b1;
              free_idx <= rd_idx;
            end
          end
          if (scan == CNT_W'(FRAMES)) begin
            rd_ok <= 1'b0;
            state <= (cur.func == FUNC_FLUSH_ALL) ? S_FLUSH : S_DECIDE;
            scan  <= '0;
          end else begin
            rd_ok  <= 1'b1;
            rd_idx <= scan[FIDX_W-1:0];
            scan   <= scan + 1'b1;
          end
        end
        S_DECIDE: begin
          if (can_push) begin
            state <= go_emit ? S_EMIT : S_IDLE;
            slot  <= (used >= cap_eff) ? vic_idx : free_idx;
          end
        end
        S_EMIT: begin
          if (can_push) begin
            valid_bits[slot] <= 1'b1;
            state <= S_IDLE;
          end
        end
        // flush all: read one frame, then write back if valid and dirty
        S_FLUSH: begin
          if (!rd_ok) begin
            if (scan == CNT_W'(FRAMES)) begin
              if (can_push) begin
                state <= S_IDLE;
              end
            end else begin
              rd_ok  <= 1'b1;
              rd_idx <= scan[FIDX_W-1:0];
              scan   <= scan + 1'b1;
            end
          end else if (!(rd_valid && rdata.dirty) || can_push) begin
            rd_ok <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !req.ready) else $error("ready while busy");
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !we) else $error("stray write");
  a_push_ok: assert property (@(posedge clk) disable iff (rst)
    push |-> can_push) else $error("push without room");
endmodule
`default_nettype wire

// ===== design/lru_buffer_pool_frame_manager.sv =====
// ---------------------------------------------------------------------------
// lru_buffer_pool_frame_manager: LRU buffer pool metadata with pin counts
// Top level: request channel, result channel, capacity register.
// ---------------------------------------------------------------------------
// Usage:
//   req carries func, page_id and set_dirty; rsp returns one or more
//   results per request, the final one marked by last. The user must write
//   capacity through cfg_we/cfg_data only while idle; it is not enforced.
// Timing:
//   Each request scans all FRAMES entries of the metadata memory, one read
//   a cycle; the result follows the scan through the decide step and the
//   output register, and a miss needing a new frame adds an install step.
//   Flush all runs the same scan, then visits each frame again, reading it
//   and writing back if valid and dirty, before the sync. The single read
//   port is why frames are visited one at a time.
//   One request is in flight at a time; req.ready is high only when idle.
// Reset:
//   rst clears all valid bits and the use clock; capacity returns to 16.
//   No clearing pass is needed.
// Stall:
//   A result waits in the output register while rsp.ready is low; the
//   sequencer holds until the register can take the next result.
// ---------------------------------------------------------------------------
`default_nettype none
module lru_buffer_pool_frame_manager import lbpfm_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [CAP_W-1:0] cfg_data,
  lbpfm_req_if.sink             req,
  lbpfm_rsp_if.source           rsp
);
  logic [CAP_W-1:0] capacity;
  logic             push;
  rsp_t             push_data;
  logic             can_push;

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_W'(16);
    end else if (cfg_we) begin
      capacity <= cfg_data;
    end
  end

  lbpfm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .capacity(capacity), .req(req),
    .push(push), .push_data(push_data), .can_push(can_push)
  );

  lbpfm_out u_out (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data),
    .can_push(can_push), .rsp(rsp)
  );
endmodule
`default_nettype wire
